FILE: hdl/srrw_pkg.sv
package srrw_pkg;

    localparam int unsigned SEQ_W          = 32;
    localparam int unsigned LEN_W          = 11;
    localparam int unsigned TAG_W          = 16;
    localparam int unsigned STATUS_W       = 3;
    localparam int unsigned CFG_W          = 16;
    localparam int unsigned CFG_INDEX_W    = 2;

    localparam int unsigned DEF_REORDER_SLOTS = 8;
    localparam int unsigned DEF_MAX_PAYLOAD   = 1024;

    localparam logic [CFG_W-1:0] WINDOW_SPAN_RESET = 16'd5120;
    localparam logic [CFG_W-1:0] PACKET_STEP_RESET = 16'd1024;
    localparam logic [SEQ_W-1:0] EXPECTED_RESET    = 32'd1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SPAN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PACKET_STEP = 2'd1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INORDER  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OLD      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BEYOND   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BUFFERED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FINISHED = 3'd6;

    // Result kinds.
    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    typedef struct packed {
        logic [SEQ_W-1:0] seq_number;
        logic             is_final;
        logic [LEN_W-1:0] payload_length;
        logic [TAG_W-1:0] payload_tag;
    } in_item_t;

    typedef struct packed {
        logic                kind;
        logic [SEQ_W-1:0]    seq_out;
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    tag_out;
        logic [LEN_W-1:0]    length_out;
        logic                final_out;
        logic                last;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic load_ack;
        logic store_slot;
        logic load_dlv;
        logic from_slot;
        logic set_last;
        logic last_val;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [STATUS_W-1:0] cls_status;
        logic                any_match;
        logic                out_final;
        logic                out_last;
    } dp_stat_t;

endpackage

FILE: hdl/srrw_ctrl.sv
module srrw_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  srrw_pkg::dp_stat_t   stat,
    output srrw_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_WAIT,
        S_DLV,
        S_LAST
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   first_reg, first_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        first_next     = first_reg;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CLASS;
                end
            end
            S_CLASS:
            begin
                cmd.load_ack   = 1'b1;
                cmd.store_slot = (stat.cls_status == srrw_pkg::ST_BUFFERED);
                cmd.last_val   = (stat.cls_status != srrw_pkg::ST_INORDER);
                first_next     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_WAIT;
            end
            S_WAIT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (stat.out_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DLV;
                    end
                end
            end
            S_DLV:
            begin
                cmd.load_dlv  = 1'b1;
                cmd.from_slot = !first_reg;
                first_next    = 1'b0;
                state_next    = S_LAST;
            end
            S_LAST:
            begin
                cmd.set_last   = 1'b1;
                cmd.last_val   = stat.out_final || !stat.any_match;
                out_valid_next = 1'b1;
                state_next     = S_WAIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            first_reg     <= first_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // A result is shown only while the controller waits on the output side.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == S_WAIT))
        else $error("result valid outside the wait state");

    // The first delivery after an acknowledgment always comes from the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLASS) |=> first_reg)
        else $error("input delivery flag not set after classification");

endmodule

FILE: hdl/srrw_dpath.sv
module srrw_dpath
#(
    parameter int unsigned REORDER_SLOTS = srrw_pkg::DEF_REORDER_SLOTS,
    parameter int unsigned MAX_PAYLOAD   = srrw_pkg::DEF_MAX_PAYLOAD
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  srrw_pkg::in_item_t                  in_data,
    output srrw_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [srrw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [srrw_pkg::CFG_W-1:0]          cfg_data,
    input  srrw_pkg::ctrl_cmd_t                 cmd,
    output srrw_pkg::dp_stat_t                  stat
);

    localparam int unsigned IDX_W = (REORDER_SLOTS > 1) ? $clog2(REORDER_SLOTS) : 1;
    localparam int unsigned LIM_W = 17;

    srrw_pkg::in_item_t              in_reg;
    srrw_pkg::out_item_t             out_reg;
    logic [srrw_pkg::CFG_W-1:0]      span_reg;
    logic [srrw_pkg::CFG_W-1:0]      step_reg;
    logic [srrw_pkg::SEQ_W-1:0]      exp_reg;
    logic                            done_reg;
    logic [REORDER_SLOTS-1:0]        valid_reg;

    logic [srrw_pkg::SEQ_W-1:0]      slot_seq   [REORDER_SLOTS];
    logic [srrw_pkg::TAG_W-1:0]      slot_tag   [REORDER_SLOTS];
    logic [srrw_pkg::LEN_W-1:0]      slot_len   [REORDER_SLOTS];
    logic                            slot_fin   [REORDER_SLOTS];

    logic [srrw_pkg::LEN_W-1:0]      len_clamped;
    logic [srrw_pkg::SEQ_W-1:0]      seq_gap;
    logic [REORDER_SLOTS-1:0]        dup_vec;
    logic [REORDER_SLOTS-1:0]        match_vec;
    logic [IDX_W-1:0]                free_idx;
    logic [IDX_W-1:0]                match_idx;
    logic [srrw_pkg::STATUS_W-1:0]   cls_status;

    // Lengths above the payload limit are clamped on entry.
    always_comb
    begin
        if ({{(LIM_W - srrw_pkg::LEN_W){1'b0}}, in_data.payload_length} > LIM_W'(MAX_PAYLOAD))
        begin
            len_clamped = srrw_pkg::LEN_W'(MAX_PAYLOAD);
        end
        else
        begin
            len_clamped = in_data.payload_length;
        end
    end

    // Slot compares and lowest-index selection.
    always_comb
    begin
        free_idx  = '0;
        match_idx = '0;
        for (int i = REORDER_SLOTS - 1; i >= 0; i--)
        begin
            dup_vec[i]   = valid_reg[i] && (slot_seq[i] == in_reg.seq_number);
            match_vec[i] = valid_reg[i] && (slot_seq[i] == exp_reg);
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
            if (match_vec[i])
            begin
                match_idx = IDX_W'(i);
            end
        end
    end

    assign seq_gap = in_reg.seq_number - exp_reg;

    always_comb
    begin
        priority if (done_reg)
        begin
            cls_status = srrw_pkg::ST_FINISHED;
        end
        else if (seq_gap == '0)
        begin
            cls_status = srrw_pkg::ST_INORDER;
        end
        else if (seq_gap[srrw_pkg::SEQ_W-1])
        begin
            cls_status = srrw_pkg::ST_OLD;
        end
        else if (seq_gap > {{(srrw_pkg::SEQ_W - srrw_pkg::CFG_W){1'b0}}, span_reg})
        begin
            cls_status = srrw_pkg::ST_BEYOND;
        end
        else if (|dup_vec)
        begin
            cls_status = srrw_pkg::ST_DUP;
        end
        else if (&valid_reg)
        begin
            cls_status = srrw_pkg::ST_FULL;
        end
        else
        begin
            cls_status = srrw_pkg::ST_BUFFERED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg  <= srrw_pkg::WINDOW_SPAN_RESET;
            step_reg  <= srrw_pkg::PACKET_STEP_RESET;
            exp_reg   <= srrw_pkg::EXPECTED_RESET;
            done_reg  <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == srrw_pkg::CFG_WINDOW_SPAN))
            begin
                span_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == srrw_pkg::CFG_PACKET_STEP))
            begin
                step_reg <= cfg_data;
            end
            if (cmd.store_slot)
            begin
                valid_reg[free_idx] <= 1'b1;
            end
            if (cmd.load_dlv)
            begin
                exp_reg <= exp_reg + {{(srrw_pkg::SEQ_W - srrw_pkg::CFG_W){1'b0}}, step_reg};
                if (cmd.from_slot)
                begin
                    valid_reg[match_idx] <= 1'b0;
                    done_reg             <= slot_fin[match_idx];
                end
                else
                begin
                    done_reg <= in_reg.is_final;
                end
            end
        end
    end

    // Payload storage: input register, slot store and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg.seq_number     <= in_data.seq_number;
            in_reg.is_final       <= in_data.is_final;
            in_reg.payload_length <= len_clamped;
            in_reg.payload_tag    <= in_data.payload_tag;
        end
        if (cmd.store_slot)
        begin
            slot_seq[free_idx] <= in_reg.seq_number;
            slot_tag[free_idx] <= in_reg.payload_tag;
            slot_len[free_idx] <= in_reg.payload_length;
            slot_fin[free_idx] <= in_reg.is_final;
        end
        if (cmd.load_ack)
        begin
            out_reg.kind       <= srrw_pkg::KIND_ACK;
            out_reg.seq_out    <= in_reg.seq_number;
            out_reg.status     <= cls_status;
            out_reg.tag_out    <= '0;
            out_reg.length_out <= '0;
            out_reg.final_out  <= 1'b0;
            out_reg.last       <= cmd.last_val;
        end
        if (cmd.load_dlv)
        begin
            out_reg.kind   <= srrw_pkg::KIND_DELIVER;
            out_reg.status <= srrw_pkg::ST_INORDER;
            out_reg.last   <= 1'b0;
            if (cmd.from_slot)
            begin
                out_reg.seq_out    <= slot_seq[match_idx];
                out_reg.tag_out    <= slot_tag[match_idx];
                out_reg.length_out <= slot_len[match_idx];
                out_reg.final_out  <= slot_fin[match_idx];
            end
            else
            begin
                out_reg.seq_out    <= in_reg.seq_number;
                out_reg.tag_out    <= in_reg.payload_tag;
                out_reg.length_out <= in_reg.payload_length;
                out_reg.final_out  <= in_reg.is_final;
            end
        end
        if (cmd.set_last)
        begin
            out_reg.last <= cmd.last_val;
        end
    end

    assign out_data        = out_reg;
    assign stat.cls_status = cls_status;
    assign stat.any_match  = |match_vec;
    assign stat.out_final  = out_reg.final_out;
    assign stat.out_last   = out_reg.last;

    // A packet is never stored into a full buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_slot |-> !(&valid_reg))
        else $error("slot store with no free slot");

    // Each delivery advances the expected sequence by one packet step.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_dlv |=> (exp_reg == $past(exp_reg)
            + {{(srrw_pkg::SEQ_W - srrw_pkg::CFG_W){1'b0}}, $past(step_reg)}))
        else $error("expected sequence did not advance by the step");

    // A drain from the buffer only happens when a held slot matches.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_dlv && cmd.from_slot) |-> (|match_vec))
        else $error("buffer delivery without a matching slot");

    // Once the end packet is delivered the transfer stays finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("finished flag cleared without reset");

endmodule

FILE: hdl/selective_repeat_receive_window.sv
// An accepted request is captured and classified; its acknowledgment is then registered and shown.
// Each in-order delivery and each drained buffer entry adds a load, a last-mark and a show step.
// Requests are taken one at a time: the next one waits until every result of the last one has
// been taken, including any output stall, as the controller steps through one result per pass.
// Reset (rst_n low, asynchronous) empties the reorder buffer, sets the expected sequence
// to 1, clears the finished flag and restores window_span 5120 and packet_step 1024.
module selective_repeat_receive_window
#(
    parameter int unsigned REORDER_SLOTS = srrw_pkg::DEF_REORDER_SLOTS,
    parameter int unsigned MAX_PAYLOAD   = srrw_pkg::DEF_MAX_PAYLOAD
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Request side: one received packet per accepted request.
    input  logic                               in_valid,
    output logic                               in_stall,
    input  srrw_pkg::in_item_t                 in_data,
    // Result side: acknowledgments and in-order deliveries.
    output logic                               out_valid,
    input  logic                               out_stall,
    output srrw_pkg::out_item_t                out_data,
    // Configuration writes: the user must make them only while the block is idle; the block does not enforce it.
    input  logic                               cfg_we,
    input  logic [srrw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [srrw_pkg::CFG_W-1:0]         cfg_data
);

    // The controller sequences each request: it captures the packet, has the
    // datapath classify it against the expected sequence and the window, and
    // emits the acknowledgment. For an in-order packet it then walks through
    // deliveries: first the packet itself, then every buffered packet that
    // continues the sequence. The last-result mark of a delivery is settled
    // in the cycle after the delivery is loaded, once the expected sequence and
    // the slot valid bits have been updated, so the datapath can tell whether
    // another buffered packet follows.
    srrw_pkg::ctrl_cmd_t cmd;
    srrw_pkg::dp_stat_t  stat;

    srrw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the configuration, the expected sequence, the
    // finished flag, the reorder slots and the result register. The slots are
    // searched in parallel; the lowest free slot takes a new packet and the
    // lowest matching slot is drained first.
    srrw_dpath
    #(
        .REORDER_SLOTS (REORDER_SLOTS),
        .MAX_PAYLOAD   (MAX_PAYLOAD)
    )
    u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

FILE: dv/selective_repeat_receive_window_tb.sv
module selective_repeat_receive_window_tb;

    import srrw_pkg::*;

    // Register indexes past the end of the register list. Writes to them must be dropped.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    // Window and step settings for the random phases. The last phase draws its own.
    localparam logic [CFG_W-1:0] SPAN_PLAN [5] = '{16'd5120, 16'd65535, 16'd0, 16'd65535, 16'd2048};
    localparam logic [CFG_W-1:0] STEP_PLAN [5] = '{16'd1024, 16'd1, 16'd1024, 16'd65535, 16'd4096};
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_PACKETS = 28;
    localparam int LONG_HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // Packets waiting to be offered, and results the window is known to owe us.
    in_item_t pending_packets [$];
    out_item_t expected_results [$];
    int packets_planned = 0;
    int mismatch_count = 0;

    // Our own copy of the receive window: expected sequence, finished flag, the
    // two registers and the reorder buffer.
    logic [SEQ_W-1:0] win_expected = EXPECTED_RESET;
    logic win_done = 1'b0;
    logic [CFG_W-1:0] win_span = WINDOW_SPAN_RESET;
    logic [CFG_W-1:0] win_step = PACKET_STEP_RESET;
    logic held_valid [DEF_REORDER_SLOTS] = '{default: 1'b0};
    logic [SEQ_W-1:0] held_seq [DEF_REORDER_SLOTS];
    logic [TAG_W-1:0] held_tag [DEF_REORDER_SLOTS];
    logic [LEN_W-1:0] held_len [DEF_REORDER_SLOTS];
    logic held_fin [DEF_REORDER_SLOTS];

    // Handshake pacing state for both sides.
    int unsigned tx_wait = 0;
    logic tx_quiet = 1'b0;
    int unsigned rx_wait = 0;
    int unsigned rx_draw;
    logic rx_quiet = 1'b0;
    logic want_long_hold = 1'b0;
    logic long_hold_taken = 1'b0;

    selective_repeat_receive_window dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic out_item_t ack_of(input logic [SEQ_W-1:0] seq,
                                         input logic [STATUS_W-1:0] verdict);
        out_item_t r;
        r = '0;
        r.kind = KIND_ACK;
        r.seq_out = seq;
        r.status = verdict;
        return r;
    endfunction

    function automatic out_item_t delivery_of(input logic [SEQ_W-1:0] seq,
                                              input logic [TAG_W-1:0] tag,
                                              input logic [LEN_W-1:0] len,
                                              input logic fin);
        out_item_t r;
        r = '0;
        r.kind = KIND_DELIVER;
        r.seq_out = seq;
        r.status = ST_INORDER;
        r.tag_out = tag;
        r.length_out = len;
        r.final_out = fin;
        return r;
    endfunction

    // Works out every result that one accepted request causes and updates the
    // window copy. The acknowledgment always comes first, then any deliveries.
    task automatic predict_window_results(input in_item_t pkt);
        out_item_t batch [$];
        logic [SEQ_W-1:0] seq_gap;
        logic [LEN_W-1:0] len;
        logic [STATUS_W-1:0] verdict;
        int hit;
        int free_slot;
        logic dup;
        logic more;
        len = (pkt.payload_length > DEF_MAX_PAYLOAD) ? LEN_W'(DEF_MAX_PAYLOAD)
                                                     : pkt.payload_length;
        seq_gap = pkt.seq_number - win_expected;
        if (win_done)
        begin
            batch.push_back(ack_of(pkt.seq_number, ST_FINISHED));
        end
        else if (seq_gap == 0)
        begin
            batch.push_back(ack_of(pkt.seq_number, ST_INORDER));
            batch.push_back(delivery_of(pkt.seq_number, pkt.payload_tag, len, pkt.is_final));
            win_expected = win_expected + SEQ_W'(win_step);
            win_done = pkt.is_final;
            more = !pkt.is_final;
            // Drain the reorder buffer while the lowest matching slot continues the
            // sequence. An end packet pulled from the buffer stops the drain.
            while (more)
            begin
                hit = -1;
                for (int i = 0; i < DEF_REORDER_SLOTS; i++)
                begin
                    if (hit < 0 && held_valid[i] && held_seq[i] == win_expected)
                        hit = i;
                end
                if (hit < 0)
                begin
                    more = 1'b0;
                end
                else
                begin
                    batch.push_back(delivery_of(held_seq[hit], held_tag[hit],
                                                held_len[hit], held_fin[hit]));
                    held_valid[hit] = 1'b0;
                    win_expected = win_expected + SEQ_W'(win_step);
                    if (held_fin[hit])
                    begin
                        win_done = 1'b1;
                        more = 1'b0;
                    end
                end
            end
        end
        else if (seq_gap >= 32'h8000_0000)
        begin
            batch.push_back(ack_of(pkt.seq_number, ST_OLD));
        end
        else if (seq_gap > SEQ_W'(win_span))
        begin
            batch.push_back(ack_of(pkt.seq_number, ST_BEYOND));
        end
        else
        begin
            dup = 1'b0;
            free_slot = -1;
            for (int i = 0; i < DEF_REORDER_SLOTS; i++)
            begin
                if (held_valid[i] && held_seq[i] == pkt.seq_number)
                    dup = 1'b1;
                if (!held_valid[i] && free_slot < 0)
                    free_slot = i;
            end
            if (dup)
            begin
                verdict = ST_DUP;
            end
            else if (free_slot < 0)
            begin
                verdict = ST_FULL;
            end
            else
            begin
                held_valid[free_slot] = 1'b1;
                held_seq[free_slot] = pkt.seq_number;
                held_tag[free_slot] = pkt.payload_tag;
                held_len[free_slot] = len;
                held_fin[free_slot] = pkt.is_final;
                verdict = ST_BUFFERED;
            end
            batch.push_back(ack_of(pkt.seq_number, verdict));
        end
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_results.push_back(batch[i]);
    endtask

    function automatic void compare_field(input string name, input logic [SEQ_W-1:0] want,
                                          input logic [SEQ_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0)
        begin
            $display("%0t: result arrived with none outstanding: %p", $time, got);
            mismatch_count++;
        end
        else
        begin
            want = expected_results.pop_front();
            compare_field("kind", SEQ_W'(want.kind), SEQ_W'(got.kind));
            compare_field("seq_out", want.seq_out, got.seq_out);
            compare_field("status", SEQ_W'(want.status), SEQ_W'(got.status));
            compare_field("tag_out", SEQ_W'(want.tag_out), SEQ_W'(got.tag_out));
            compare_field("length_out", SEQ_W'(want.length_out), SEQ_W'(got.length_out));
            compare_field("final_out", SEQ_W'(want.final_out), SEQ_W'(got.final_out));
            compare_field("last", SEQ_W'(want.last), SEQ_W'(got.last));
        end
    endtask

    // Request driver. A request stays on the bus unchanged while the window
    // stalls it. Once it is taken, the predictor runs, and the driver idles for
    // the gap drawn with that request before offering the next one. Quiet
    // stretches with no gaps come and go at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            tx_wait <= 0;
            tx_quiet <= 1'b0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
                predict_window_results(in_data);
            if (tx_wait != 0)
            begin
                tx_wait <= tx_wait - 1;
                in_valid <= 1'b0;
            end
            else if (pending_packets.size() != 0)
            begin
                in_data <= pending_packets.pop_front();
                in_valid <= 1'b1;
                tx_wait <= tx_quiet ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 31) == 0)
                    tx_quiet <= !tx_quiet;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result monitor. Every accepted result is checked against the oldest
    // expectation, and then the stall is held for a drawn number of cycles.
    // Once, on request from the stimulus, it holds off for a long stretch so
    // that the window backs up and stalls its requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_wait <= 0;
            rx_quiet <= 1'b0;
            long_hold_taken <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result(out_data);
            if (want_long_hold && !long_hold_taken)
            begin
                long_hold_taken <= 1'b1;
                rx_wait <= LONG_HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (out_valid && !out_stall)
            begin
                rx_draw = rx_quiet ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 31) == 0)
                    rx_quiet <= !rx_quiet;
                rx_wait <= rx_draw;
                out_stall <= (rx_draw != 0);
            end
            else if (rx_wait > 1)
            begin
                rx_wait <= rx_wait - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                rx_wait <= 0;
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [LEN_W-1:0] rand_length();
        if ($urandom_range(0, 3) == 0)
            return LEN_W'($urandom_range(0, 2047));
        return LEN_W'($urandom_range(0, DEF_MAX_PAYLOAD));
    endfunction

    function automatic logic [TAG_W-1:0] rand_tag();
        return TAG_W'($urandom_range(0, 65535));
    endfunction

    task automatic queue_packet(input logic [SEQ_W-1:0] seq, input logic fin,
                                input logic [LEN_W-1:0] len, input logic [TAG_W-1:0] tag);
        in_item_t pkt;
        pkt.seq_number = seq;
        pkt.is_final = fin;
        pkt.payload_length = len;
        pkt.payload_tag = tag;
        pending_packets.push_back(pkt);
        packets_planned++;
    endtask

    // Stimulus runs on falling edges so that it never touches the queues in the
    // same step as the driver and monitor. Idle means no request pending or on
    // the bus and no result outstanding.
    task automatic wait_idle();
        @(negedge clk);
        while (pending_packets.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Register writes happen only while idle, so the copy can change right away.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WINDOW_SPAN)
            win_span = value;
        else if (idx == CFG_PACKET_STEP)
            win_step = value;
        @(negedge clk);
    endtask

    // Sends the in-order run that covers every packet still held, so that a new
    // step never leaves entries stranded in the buffer.
    task automatic flush_held();
        logic [SEQ_W-1:0] reach;
        logic [SEQ_W-1:0] seq_gap;
        int unsigned count;
        reach = '0;
        for (int i = 0; i < DEF_REORDER_SLOTS; i++)
        begin
            seq_gap = held_seq[i] - win_expected;
            if (held_valid[i] && seq_gap < 32'h8000_0000 && seq_gap > reach)
                reach = seq_gap;
        end
        if (reach != 0 && win_step != 0)
        begin
            count = reach / win_step + 1;
            for (int k = 0; k < count; k++)
                queue_packet(win_expected + win_step * k, 1'b0, rand_length(), rand_tag());
            wait_idle();
        end
    endtask

    // Packets the window only acknowledges: retransmits of delivered data, and
    // far-off sequence numbers kept well clear of the window as it moves. The end
    // mark is random on these since they are never stored.
    task automatic queue_noise();
        logic [SEQ_W-1:0] seq;
        case ($urandom_range(0, 2))
            0: seq = win_expected - win_step * $urandom_range(1, 8);
            1: seq = win_expected - $urandom_range(1, 100000);
            default:
            begin
                seq = $urandom;
                while (seq - win_expected < SEQ_W'(win_span) + 32'h0100_0000)
                    seq = $urandom;
            end
        endcase
        queue_packet(seq, 1'($urandom_range(0, 1)), rand_length(), rand_tag());
    endtask

    // A well-formed run of consecutive packets from the expected sequence on, in
    // shuffled order, with some lost, some repeated and some noise mixed in.
    task automatic random_burst();
        int order [10];
        int run;
        int j;
        int swap;
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] seq;
        base = win_expected;
        run = $urandom_range(1, 10);
        for (int i = 0; i < run; i++)
            order[i] = i;
        for (int i = run - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            swap = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        for (int i = 0; i < run; i++)
        begin
            seq = base + win_step * order[i];
            if ($urandom_range(0, 4) == 0)
                queue_noise();
            if ($urandom_range(0, 7) != 0)
                queue_packet(seq, 1'b0, rand_length(), rand_tag());
            if ($urandom_range(0, 7) == 0)
                queue_packet(seq, 1'b0, rand_length(), rand_tag());
        end
    endtask

    initial
    begin
        logic [SEQ_W-1:0] e;
        logic [SEQ_W-1:0] st;
        logic [CFG_W-1:0] span_val;
        logic [CFG_W-1:0] step_val;
        int phase_start;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed classification with the reset window of five packets. The
        // first packet is in order; its repeat is then old. The packet at exactly
        // the window end is buffered and one byte further is beyond. Two more
        // are buffered out of order, one of them with an oversized length that
        // must be clamped, and the missing packets then drain the buffer.
        e = win_expected;
        st = SEQ_W'(win_step);
        queue_packet(e, 1'b0, LEN_W'(DEF_MAX_PAYLOAD), 16'hFFFF);
        queue_packet(e, 1'b1, 11'd0, 16'h0000);
        queue_packet(e + st + SEQ_W'(WINDOW_SPAN_RESET), 1'b0, 11'd1025, 16'hA5A5);
        queue_packet(e + st + SEQ_W'(WINDOW_SPAN_RESET) + 1, 1'b1, 11'd7, 16'h1234);
        queue_packet(e + st + SEQ_W'(WINDOW_SPAN_RESET), 1'b0, 11'd3, 16'h5A5A);
        queue_packet(e + 3 * st, 1'b0, 11'd2047, 16'h0000);
        queue_packet(e + 2 * st, 1'b0, 11'd1, 16'hFFFF);
        queue_packet(e + st, 1'b0, 11'd1024, 16'h8001);
        queue_packet(e + 4 * st, 1'b0, 11'd512, 16'h7FFE);
        queue_packet(e + 5 * st, 1'b0, 11'd1023, 16'h0F0F);
        // Sequence numbers at the ends of the range and at half the range away
        // from the expected sequence, where old turns into beyond.
        queue_packet(32'h0000_0000, 1'b1, 11'd0, 16'h0001);
        queue_packet(32'hFFFF_FFFF, 1'b1, 11'd2047, 16'hFFFF);
        queue_packet(e + 7 * st + 32'h8000_0000, 1'b0, 11'd10, 16'h2222);
        queue_packet(e + 7 * st + 32'h7FFF_FFFF, 1'b1, 11'd20, 16'h3333);
        wait_idle();

        // Widest window, plus writes to indexes that do not exist.
        write_reg(CFG_WINDOW_SPAN, 16'hFFFF);
        write_reg(CFG_SPARE_LO, 16'h0001);
        write_reg(CFG_SPARE_HI, 16'h0000);

        // Fill all reorder slots, overflow them, then release the whole buffer
        // with the missing packet: the longest run of results one request makes.
        e = win_expected;
        st = SEQ_W'(win_step);
        for (int i = 1; i <= DEF_REORDER_SLOTS; i++)
            queue_packet(e + st * i, 1'b0, rand_length(), rand_tag());
        queue_packet(e + st * (DEF_REORDER_SLOTS + 1), 1'b0, rand_length(), 16'hBEEF);
        queue_packet(e, 1'b0, rand_length(), rand_tag());
        wait_idle();

        // Random phases, each under its own window and step.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            flush_held();
            if (p < 5)
            begin
                span_val = SPAN_PLAN[p];
                step_val = STEP_PLAN[p];
            end
            else
            begin
                span_val = CFG_W'($urandom_range(0, 65535));
                step_val = CFG_W'($urandom_range(1, 65535));
            end
            write_reg(CFG_WINDOW_SPAN, span_val);
            write_reg(CFG_PACKET_STEP, step_val);
            if (p == 0)
            begin
                // The monitor holds off for a long time while two bursts queue up.
                @(posedge clk);
                want_long_hold <= 1'b1;
                @(negedge clk);
                random_burst();
                random_burst();
                wait_idle();
            end
            phase_start = packets_planned;
            while (packets_planned - phase_start < PHASE_PACKETS)
            begin
                random_burst();
                wait_idle();
            end
        end

        // A packet between two step positions is buffered and then passed over,
        // so it keeps its slot for good. The buffer now overflows one packet
        // earlier than before.
        flush_held();
        write_reg(CFG_WINDOW_SPAN, 16'hFFFF);
        write_reg(CFG_PACKET_STEP, PACKET_STEP_RESET);
        e = win_expected;
        st = SEQ_W'(win_step);
        queue_packet(e + st / 2, 1'b0, rand_length(), 16'h0BAD);
        queue_packet(e, 1'b0, rand_length(), rand_tag());
        e = e + st;
        for (int i = 1; i < DEF_REORDER_SLOTS; i++)
            queue_packet(e + st * i, 1'b0, rand_length(), rand_tag());
        queue_packet(e + st * DEF_REORDER_SLOTS, 1'b0, rand_length(), 16'hF00D);
        queue_packet(e, 1'b0, rand_length(), rand_tag());
        wait_idle();

        // With a zero step the expected sequence stands still, so the same
        // packet is delivered again and again.
        write_reg(CFG_PACKET_STEP, 16'd0);
        e = win_expected;
        queue_packet(e, 1'b0, rand_length(), 16'h1111);
        queue_packet(e, 1'b0, rand_length(), 16'h2222);
        wait_idle();

        // The end packet is buffered ahead of another one. The drain stops at
        // the end packet, and from then on every request is answered as finished.
        write_reg(CFG_PACKET_STEP, PACKET_STEP_RESET);
        e = win_expected;
        st = SEQ_W'(win_step);
        queue_packet(e + 2 * st, 1'b0, rand_length(), 16'h4444);
        queue_packet(e + st, 1'b1, rand_length(), 16'h5555);
        queue_packet(e, 1'b0, rand_length(), 16'h6666);
        queue_packet(e + 2 * st, 1'b0, rand_length(), 16'h7777);
        queue_packet($urandom, 1'b0, rand_length(), rand_tag());
        queue_packet(e, 1'b1, rand_length(), 16'h8888);
        wait_idle();
        repeat (10) @(negedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
